// ----- src/idba_pkg.sv -----
// shared types and constants of the identifier bitmap allocator
`timescale 1ns / 1ps

package idba_pkg;

   // identifier space and in-use map geometry
   localparam int ID_SPACE = 8192;
   localparam int ID_W     = $clog2(ID_SPACE);
   localparam int WORD_W   = 32;
   localparam int BIT_W    = $clog2(WORD_W);
   localparam int NUM_ROWS = ID_SPACE / WORD_W;
   localparam int ROW_W    = $clog2(NUM_ROWS);

   // register reset values
   localparam logic [ID_W-1:0] MIN_ID_RESET = ID_W'(300);
   localparam logic [ID_W-1:0] MAX_ID_RESET = ID_W'(5000);

   // register indexes
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ID = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ID = CSR_IDX_W'(1);

   typedef enum logic {
      OP_ALLOC   = 1'b0,
      OP_RELEASE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ALLOCATED    = 2'd0,
      ST_NONE_FREE    = 2'd1,
      ST_RELEASED     = 2'd2,
      ST_OUT_OF_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      op_type          op;
      logic [ID_W-1:0] id;
   } req_payload_type;

   typedef struct packed {
      logic [ID_W-1:0] id_out;
      status_type      status;
   } rsp_payload_type;

   // access to the in-use map
   typedef struct packed {
      logic              rd_en;
      logic [ROW_W-1:0]  rd_row;
      logic              wr_en;
      logic [ROW_W-1:0]  wr_row;
      logic [WORD_W-1:0] wr_data;
   } map_req_type;

endpackage

// ----- src/idba_map.sv -----
// in-use map: word memory with per-row written flags so reset frees every id
`timescale 1ns / 1ps

module idba_map (
   input  logic                           clock,
   input  logic                           reset,
   input  idba_pkg::map_req_type          map_req,
   output logic [idba_pkg::WORD_W-1:0]    rd_data
);

   logic [idba_pkg::WORD_W-1:0]   mem_ff [idba_pkg::NUM_ROWS];
   logic [idba_pkg::NUM_ROWS-1:0] row_vld_ff;
   logic [idba_pkg::WORD_W-1:0]   rd_word_ff;
   logic                          rd_vld_ff;

   // row written flags, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (map_req.wr_en) begin
         row_vld_ff[map_req.wr_row] <= 1'b1;
      end
   end

   // word storage with registered read
   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem_ff[map_req.wr_row] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_word_ff <= mem_ff[map_req.rd_row];
         rd_vld_ff  <= row_vld_ff[map_req.rd_row];
      end
   end

   // a row never written reads as all free
   assign rd_data = rd_vld_ff ? rd_word_ff : '0;

endmodule

// ----- src/id_bitmap_allocator.sv -----
// Next-fit identifier allocator over a one-bit in-use map of 8192 ids kept as 256 words
// of 32 bits. A release goes through a range check with map read, then a write back,
// before its response; one that is out of range is answered from the range check. An
// allocate scans the map word by word: the scan runs from the search pointer up to
// max_id, then from min_id back to the pointer, reading one word per cycle from the single
// map read port and testing it with one masked find-first unit. One request is in work at
// a time; the next is taken once the response has been accepted. The map is free right
// after reset (per-word written flags, no clearing pass). Registers are to be written
// only while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module id_bitmap_allocator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  idba_pkg::req_payload_type            req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output idba_pkg::rsp_payload_type            rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [idba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [idba_pkg::ID_W-1:0]            csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_SCAN   = 5'b00100,
      S_REL    = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   localparam int ID_W   = idba_pkg::ID_W;
   localparam int BIT_W  = idba_pkg::BIT_W;
   localparam int ROW_W  = idba_pkg::ROW_W;
   localparam int WORD_W = idba_pkg::WORD_W;

   // true when the walk step at this row is the final one
   function automatic logic walk_last(input logic phase, input logic [ROW_W-1:0] row,
                                      input logic [ID_W-1:0] cur,
                                      input logic [ID_W-1:0] lo,
                                      input logic [ID_W-1:0] hi);
      logic [ID_W-1:0]  cur_m1;
      logic [ROW_W-1:0] end_row;
      cur_m1  = cur - ID_W'(1);
      end_row = phase ? cur_m1[ID_W-1:BIT_W] : hi[ID_W-1:BIT_W];
      return (row == end_row) && (phase || (cur == lo));
   endfunction

   // next walk step as {more, phase, row}
   function automatic logic [ROW_W+1:0] walk_next(input logic phase,
                                                 input logic [ROW_W-1:0] row,
                                                 input logic [ID_W-1:0] cur,
                                                 input logic [ID_W-1:0] lo,
                                                 input logic [ID_W-1:0] hi);
      logic [ID_W-1:0]  cur_m1;
      logic [ROW_W-1:0] end_row;
      logic [ROW_W+1:0] step;
      cur_m1  = cur - ID_W'(1);
      end_row = phase ? cur_m1[ID_W-1:BIT_W] : hi[ID_W-1:BIT_W];
      if (row != end_row) begin
         step = {1'b1, phase, row + ROW_W'(1)};
      end else if (!phase && (cur != lo)) begin
         step = {1'b1, 1'b1, lo[ID_W-1:BIT_W]};
      end else begin
         step = {1'b0, phase, row};
      end
      return step;
   endfunction

   state_type                  state_ff, state_in;
   idba_pkg::req_payload_type  req_ff, req_in;
   logic [ID_W-1:0]            min_id_ff, min_id_in;
   logic [ID_W-1:0]            max_id_ff, max_id_in;
   logic [ID_W-1:0]            search_ff, search_in;
   logic [ID_W-1:0]            cur_ff, cur_in;
   logic                       is_more_ff, is_more_in;
   logic                       is_phase_ff, is_phase_in;
   logic [ROW_W-1:0]           is_row_ff, is_row_in;
   logic                       ev_valid_ff, ev_valid_in;
   logic                       ev_phase_ff, ev_phase_in;
   logic [ROW_W-1:0]           ev_row_ff, ev_row_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   idba_pkg::rsp_payload_type  rsp_ff, rsp_in;

   idba_pkg::map_req_type      map_req;
   logic [WORD_W-1:0]          map_rd_data;

   logic [ID_W-1:0]            cur_start;
   logic [ID_W-1:0]            ev_lo;
   logic [ID_W-1:0]            ev_hi;
   logic [WORD_W-1:0]          mask_lo;
   logic [WORD_W-1:0]          mask_hi;
   logic [WORD_W-1:0]          free_bits;
   logic                       found;
   logic [BIT_W-1:0]           found_bit;
   logic [ID_W-1:0]            found_id;
   logic                       ev_last;

   idba_map u_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (map_rd_data)
   );

   // scan start: pointer, or min_id when the pointer left the range
   assign cur_start = ((search_ff < min_id_ff) || (search_ff > max_id_ff)) ? min_id_ff
                                                                           : search_ff;

   // masked find-first over the word under evaluation
   always_comb begin
      ev_lo     = ev_phase_ff ? min_id_ff : cur_ff;
      ev_hi     = ev_phase_ff ? (cur_ff - ID_W'(1)) : max_id_ff;
      mask_lo   = (ev_row_ff == ev_lo[ID_W-1:BIT_W])
                  ? ~((WORD_W'(1) << ev_lo[BIT_W-1:0]) - WORD_W'(1)) : '1;
      mask_hi   = (ev_row_ff == ev_hi[ID_W-1:BIT_W])
                  ? ((WORD_W'(2) << ev_hi[BIT_W-1:0]) - WORD_W'(1)) : '1;
      free_bits = ~map_rd_data & mask_lo & mask_hi;
      found     = |free_bits;
      found_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            found_bit = BIT_W'(b);
         end
      end
      found_id  = {ev_row_ff, found_bit};
      ev_last   = walk_last(ev_phase_ff, ev_row_ff, cur_ff, min_id_ff, max_id_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      min_id_in    = min_id_ff;
      max_id_in    = max_id_ff;
      search_in    = search_ff;
      cur_in       = cur_ff;
      is_more_in   = is_more_ff;
      is_phase_in  = is_phase_ff;
      is_row_in    = is_row_ff;
      ev_valid_in  = 1'b0;
      ev_phase_in  = is_phase_ff;
      ev_row_in    = is_row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      map_req      = '0;

      // register writes
      if (csr_valid) begin
         case (csr_index)
            idba_pkg::CSR_MIN_ID: min_id_in = csr_wdata;
            idba_pkg::CSR_MAX_ID: max_id_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            if (req_ff.op == idba_pkg::OP_RELEASE) begin
               if ((req_ff.id < min_id_ff) || (req_ff.id > max_id_ff)) begin
                  rsp_in.id_out = '0;
                  rsp_in.status = idba_pkg::ST_OUT_OF_RANGE;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  map_req.rd_en  = 1'b1;
                  map_req.rd_row = req_ff.id[ID_W-1:BIT_W];
                  state_in       = S_REL;
               end
            end else if (max_id_ff < min_id_ff) begin
               rsp_in.id_out = '0;
               rsp_in.status = idba_pkg::ST_NONE_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else begin
               cur_in         = cur_start;
               map_req.rd_en  = 1'b1;
               map_req.rd_row = cur_start[ID_W-1:BIT_W];
               ev_valid_in    = 1'b1;
               ev_phase_in    = 1'b0;
               ev_row_in      = cur_start[ID_W-1:BIT_W];
               {is_more_in, is_phase_in, is_row_in} =
                  walk_next(1'b0, cur_start[ID_W-1:BIT_W], cur_start, min_id_ff, max_id_ff);
               state_in       = S_SCAN;
            end
         end

         S_SCAN: begin
            if (ev_valid_ff && found) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_row  = ev_row_ff;
               map_req.wr_data = map_rd_data | (WORD_W'(1) << found_bit);
               search_in       = (found_id == max_id_ff) ? min_id_ff
                                                         : (found_id + ID_W'(1));
               rsp_in.id_out   = found_id;
               rsp_in.status   = idba_pkg::ST_ALLOCATED;
               rsp_valid_in    = 1'b1;
               state_in        = S_RESP;
            end else if (ev_valid_ff && ev_last) begin
               rsp_in.id_out = '0;
               rsp_in.status = idba_pkg::ST_NONE_FREE;
               rsp_valid_in  = 1'b1;
               state_in      = S_RESP;
            end else if (is_more_ff) begin
               map_req.rd_en  = 1'b1;
               map_req.rd_row = is_row_ff;
               ev_valid_in    = 1'b1;
               {is_more_in, is_phase_in, is_row_in} =
                  walk_next(is_phase_ff, is_row_ff, cur_ff, min_id_ff, max_id_ff);
            end
         end

         S_REL: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_row  = req_ff.id[ID_W-1:BIT_W];
            map_req.wr_data = map_rd_data & ~(WORD_W'(1) << req_ff.id[BIT_W-1:0]);
            rsp_in.id_out   = req_ff.id;
            rsp_in.status   = idba_pkg::ST_RELEASED;
            rsp_valid_in    = 1'b1;
            state_in        = S_RESP;
         end

         S_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         min_id_ff    <= idba_pkg::MIN_ID_RESET;
         max_id_ff    <= idba_pkg::MAX_ID_RESET;
         search_ff    <= idba_pkg::MIN_ID_RESET;
         is_more_ff   <= 1'b0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_id_ff    <= min_id_in;
         max_id_ff    <= max_id_in;
         search_ff    <= search_in;
         is_more_ff   <= is_more_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      cur_ff      <= cur_in;
      is_phase_ff <= is_phase_in;
      is_row_ff   <= is_row_in;
      ev_phase_ff <= ev_phase_in;
      ev_row_ff   <= ev_row_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   // a new request is never taken while a response is pending
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid_ff)
      else $error("request taken while a response is pending");

   // an accepted request closes the input until its response is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input still open after a request was taken");

   // a taken response reopens the input
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (req_ready && !rsp_valid))
      else $error("block not idle after response handshake");

   // failed requests return a zero identifier
   a_fail_zero_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_payload.status == idba_pkg::ST_NONE_FREE) ||
                     (rsp_payload.status == idba_pkg::ST_OUT_OF_RANGE)))
      |-> (rsp_payload.id_out == '0))
      else $error("failure response carries a nonzero identifier");

   // word evaluation happens only during a scan
   a_eval_in_scan: assert property (@(posedge clock) disable iff (reset)
      ev_valid_ff |-> (state_ff == S_SCAN))
      else $error("map word evaluated outside of a scan");

endmodule
